// ===== design/frst_pkg.sv =====
// frst_pkg: shared types and constants for the range-sum table
// item layout, sequencer states and fixed field widths
// no dependencies
`default_nettype none

package frst_pkg;

  localparam int POS_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;
  localparam int CNT_W = 11;

  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VAL_RD,
    ST_UPD,
    ST_QRY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                    kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] new_value;
    logic [POS_W-1:0]        range_low;
    logic [POS_W-1:0]        range_high;
  } item_t;

endpackage

`default_nettype wire

// ===== design/frst_ram.sv =====
// frst_ram: simple dual-port synchronous ram, one write and one read port
// read data registered; no dependencies
`default_nettype none

module frst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/frst_walk.sv =====
// frst_walk: sequencer and datapath for tree updates and prefix walks
// owns the element and tree memories; depends on frst_pkg and frst_ram
`default_nettype none

module frst_walk
  import frst_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire item_t             item,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire logic [CNT_W-1:0]  elem_count,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output logic [SUM_W-1:0]       res_sum
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int W  = $clog2(MAX_ELEMENTS + 1) + 1;
  localparam int CW = (W > CNT_W) ? W : CNT_W;

  state_t state_r, state_nxt;

  logic [AW-1:0]    clr_r, clr_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [POS_W-1:0] lo_r, lo_nxt;
  logic [W-1:0]     i_r, i_nxt;
  logic [W-1:0]     wr_idx_r, wr_idx_nxt;
  logic [SUM_W-1:0] delta_r, delta_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic             pend_r, pend_nxt;
  logic             pend_sub_r, pend_sub_nxt;
  logic             phase_r, phase_nxt;

  // effective count and clamped walk starts
  logic [CW-1:0] n_w;
  logic [CW-1:0] hi_ext, hi_cl, lo_ext, lo_cl, pos1_w;
  logic [W-1:0]  pos1, i_low, i_up, i_dn, i_m1, wr_m1;
  logic          i_in_range, pos_ok;

  logic             elem_we;
  logic [AW-1:0]    elem_waddr, elem_raddr;
  logic [VAL_W-1:0] elem_wdata, elem_rdata;
  logic             tree_we;
  logic [AW-1:0]    tree_waddr, tree_raddr;
  logic [SUM_W-1:0] tree_wdata, tree_rdata;

  assign n_w = (CW'(elem_count) > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : CW'(elem_count);

  assign hi_ext = CW'(item.range_high) + CW'(1);
  assign hi_cl  = (hi_ext > n_w) ? n_w : hi_ext;
  assign lo_ext = CW'(lo_r);
  assign lo_cl  = (lo_ext > n_w) ? n_w : lo_ext;
  assign pos_ok = CW'(item.position) < n_w;
  assign pos1_w = CW'(pos_r) + CW'(1);
  assign pos1   = pos1_w[W-1:0];

  assign i_low      = i_r & (~i_r + W'(1));
  assign i_up       = i_r + i_low;
  assign i_dn       = i_r & (i_r - W'(1));
  assign i_m1       = i_r - W'(1);
  assign wr_m1      = wr_idx_r - W'(1);
  assign i_in_range = CW'(i_r) <= n_w;

  frst_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (elem_wdata),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  frst_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ELEMENTS)) u_tree_ram (
    .clk   (clk),
    .we    (tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (tree_raddr),
    .rdata (tree_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      pend_r   <= 1'b0;
      phase_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      pend_r   <= pend_nxt;
      phase_r  <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    lo_r       <= lo_nxt;
    i_r        <= i_nxt;
    wr_idx_r   <= wr_idx_nxt;
    delta_r    <= delta_nxt;
    acc_r      <= acc_nxt;
    pend_sub_r <= pend_sub_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    pos_nxt      = pos_r;
    val_nxt      = val_r;
    lo_nxt       = lo_r;
    i_nxt        = i_r;
    wr_idx_nxt   = wr_idx_r;
    delta_nxt    = delta_r;
    acc_nxt      = acc_r;
    pend_nxt     = pend_r;
    pend_sub_nxt = pend_sub_r;
    phase_nxt    = phase_r;

    item_ready = 1'b0;
    res_valid  = 1'b0;

    elem_we    = 1'b0;
    elem_waddr = AW'(pos_r);
    elem_wdata = val_r;
    elem_raddr = AW'(item.position);
    tree_we    = 1'b0;
    tree_waddr = AW'(wr_m1);
    tree_wdata = tree_rdata + delta_r;
    tree_raddr = AW'(i_m1);

    case (state_r)
      ST_CLEAR: begin
        elem_we    = 1'b1;
        elem_waddr = clr_r;
        elem_wdata = '0;
        tree_we    = 1'b1;
        tree_waddr = clr_r;
        tree_wdata = '0;
        clr_nxt    = clr_r + AW'(1);
        if (clr_r == AW'(MAX_ELEMENTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          pos_nxt = item.position;
          val_nxt = item.new_value;
          lo_nxt  = item.range_low;
          if (item.kind == KIND_QUERY) begin
            i_nxt     = hi_cl[W-1:0];
            phase_nxt = 1'b0;
            pend_nxt  = 1'b0;
            acc_nxt   = '0;
            state_nxt = ST_QRY;
          end else if (pos_ok) begin
            // old value read issued this cycle from the item position
            state_nxt = ST_VAL_RD;
          end
        end
      end
      ST_VAL_RD: begin
        delta_nxt  = {{(SUM_W-VAL_W){val_r[VAL_W-1]}}, val_r}
                   - {{(SUM_W-VAL_W){elem_rdata[VAL_W-1]}}, elem_rdata};
        elem_we    = 1'b1;
        tree_raddr = AW'(pos_r);
        wr_idx_nxt = pos1;
        i_nxt      = pos1 + (pos1 & (~pos1 + W'(1)));
        pend_nxt   = 1'b1;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        // write node read last cycle while reading the next one
        tree_we = pend_r;
        if (i_in_range) begin
          wr_idx_nxt = i_r;
          i_nxt      = i_up;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      ST_QRY: begin
        if (pend_r) begin
          acc_nxt = pend_sub_r ? (acc_r - tree_rdata) : (acc_r + tree_rdata);
        end
        if (i_r != '0) begin
          pend_nxt     = 1'b1;
          pend_sub_nxt = phase_r;
          i_nxt        = i_dn;
        end else if (!phase_r) begin
          pend_nxt  = 1'b0;
          phase_nxt = 1'b1;
          i_nxt     = lo_cl[W-1:0];
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res_sum = acc_r;

  // an assignment only reaches the old-value read with an in-range position
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VAL_RD) |-> (CW'(pos_r) < n_w))
    else $error("assignment position past element count");

  // update path never reads and writes the same node in one cycle
  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && pend_r && i_in_range) |-> (tree_waddr != tree_raddr))
    else $error("tree read and write collide");

  // prefix walk index stays within the live element count
  a_qry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QRY) |-> (CW'(i_r) <= n_w))
    else $error("prefix walk index past element count");

  // a stalled result holds its value
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_sum)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

// ===== design/fenwick_range_sum_table.sv =====
// fenwick_range_sum_table: binary indexed tree with point assignment and range-sum query
//
// input channel (in_*): one transaction per item. in_kind selects an assignment
//   (position, new_value) or a range-sum query (range_low..range_high).
// result channel (out_*): one 64-bit wrapping sum per query, none per assignment.
// config channel (cfg_*): element_count, always ready; write only while idle.
// an assignment reads the old element value, then writes the element and walks
//   the update path, writing each tree node read on the step before.
// a query walks the prefix path from range_high + 1, then from range_low;
//   the single tree memory read port allows one tree read at a time.
//   the result passes through ST_DONE and the output register to out_valid.
// one item is in work at a time; in_ready drops while it is walked.
// reset: both memories are swept to zero, one entry per cycle, with in_ready
//   low until the sweep ends; element_count returns to 1024.
// a stalled receiver holds the result in the output register; the next item is
//   still taken, and a following query waits for the register to drain.
// depends on frst_pkg, frst_walk, frst_ram
`default_nettype none

module fenwick_range_sum_table
  import frst_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_kind,
  input  wire logic [POS_W-1:0]         in_position,
  input  wire logic signed [VAL_W-1:0]  in_new_value,
  input  wire logic [POS_W-1:0]         in_range_low,
  input  wire logic [POS_W-1:0]         in_range_high,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [SUM_W-1:0]       out_range_sum,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CNT_W-1:0]         cfg_element_count
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0] out_sum_r, out_sum_nxt;

  item_t            item;
  logic             res_valid, res_ready;
  logic [SUM_W-1:0] res_sum;

  assign item.kind       = in_kind;
  assign item.position   = in_position;
  assign item.new_value  = in_new_value;
  assign item.range_low  = in_range_low;
  assign item.range_high = in_range_high;

  frst_walk #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .elem_count (count_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_sum    (res_sum)
  );

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;
    if (cfg_valid) begin
      count_nxt = cfg_element_count;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_sum_nxt   = res_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sum_r <= out_sum_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

endmodule

`default_nettype wire
